// ===== rtl/core/htbd_pkg.sv =====
// shared types and constants of the huffman tree bit decoder
package htbd_pkg;

  localparam int IDX_W              = 9;
  localparam int SYM_W              = 8;
  localparam int NODE_COUNT_DEFAULT = 512;
  localparam int SYM_COUNT_DEFAULT  = 256;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_HERE  = 3'b010,
    ST_THERE = 3'b100
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] symbol;
    logic             leaf;
  } node_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             idx_ok;
    node_t            node;
    logic             code_bit;
    logic             eos;
  } cmd_t;

endpackage

// ===== rtl/core/htbd_front.sv =====
// input classification: range check of the node index and symbol clamping
module htbd_front import htbd_pkg::*; #(
  parameter int NODE_COUNT   = NODE_COUNT_DEFAULT,
  parameter int SYMBOL_COUNT = SYM_COUNT_DEFAULT
) (
  input  logic             opcode_i,
  input  logic [IDX_W-1:0] node_index_i,
  input  logic [IDX_W-1:0] left_child_i,
  input  logic [IDX_W-1:0] right_child_i,
  input  logic [SYM_W-1:0] node_symbol_i,
  input  logic             node_is_leaf_i,
  input  logic             code_bit_i,
  input  logic             end_of_stream_i,
  output cmd_t             cmd_o
);

  logic [SYM_W-1:0] sym_clamped;

  always_comb begin
    if (32'(node_symbol_i) >= SYMBOL_COUNT) begin
      sym_clamped = SYM_W'(SYMBOL_COUNT - 1);
    end else begin
      sym_clamped = node_symbol_i;
    end
  end

  always_comb begin
    cmd_o.op          = op_e'(opcode_i);
    cmd_o.idx         = node_index_i;
    cmd_o.idx_ok      = 32'(node_index_i) < NODE_COUNT;
    cmd_o.node.left   = left_child_i;
    cmd_o.node.right  = right_child_i;
    cmd_o.node.symbol = sym_clamped;
    cmd_o.node.leaf   = node_is_leaf_i;
    cmd_o.code_bit    = code_bit_i;
    cmd_o.eos         = end_of_stream_i;
  end

endmodule

// ===== rtl/core/htbd_queue.sv =====
// two-entry command queue between front and back
module htbd_queue import htbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = slot_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (32'(wptr_q) == QUEUE_DEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == QUEUE_DEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/htbd_back.sv =====
// node memory, tree walk sequencer and result register
module htbd_back import htbd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] root_i,
  input  logic             head_valid_i,
  input  cmd_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             symbol_valid_o,
  output logic [SYM_W-1:0] decoded_symbol_o,
  output logic             stream_done_o,
  output logic             stream_error_o
);

  localparam int AW = $clog2(NODE_COUNT);

  node_t            mem [NODE_COUNT];

  state_e           state_q, state_d;
  node_t            rd_q;
  logic             rd_ok_q;
  node_t            rd_node;
  logic             rd_req;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;

  logic             bit_q, bit_d;
  logic             eos_q, eos_d;
  logic [IDX_W-1:0] nxt_q, nxt_d;
  node_t            here_q, here_d;
  logic [IDX_W-1:0] here_idx_q, here_idx_d;
  logic             here_vld_q, here_vld_d;

  logic             out_vld_q, out_vld_d;
  logic             sv_q, sv_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             done_q, done_d;
  logic             err_q, err_d;
  logic             slot_free;
  logic             load_out;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign rd_node   = rd_ok_q ? rd_q : '0;

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    rd_req     = 1'b0;
    rd_idx     = root_i;
    bit_d      = bit_q;
    eos_d      = eos_q;
    nxt_d      = nxt_q;
    here_d     = here_q;
    here_idx_d = here_idx_q;
    here_vld_d = here_vld_q;
    load_out   = 1'b0;
    sv_d       = sv_q;
    sym_d      = sym_q;
    done_d     = done_q;
    err_d      = err_q;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i && head_i.op == OP_WRITE) begin
          pop_o = 1'b1;
          wr_en = head_i.idx_ok;
          if (here_vld_q && head_i.idx_ok && head_i.idx == here_idx_q) begin
            here_d = head_i.node;
          end
        end else if (head_valid_i && head_i.op == OP_DECODE && slot_free) begin
          pop_o  = 1'b1;
          rd_req = 1'b1;
          bit_d  = head_i.code_bit;
          eos_d  = head_i.eos;
          if (here_vld_q) begin
            nxt_d   = head_i.code_bit ? here_q.right : here_q.left;
            rd_idx  = nxt_d;
            state_d = ST_THERE;
          end else begin
            rd_idx  = root_i;
            state_d = ST_HERE;
          end
        end
      end
      ST_HERE: begin
        nxt_d   = bit_q ? rd_node.right : rd_node.left;
        rd_req  = 1'b1;
        rd_idx  = nxt_d;
        state_d = ST_THERE;
      end
      ST_THERE: begin
        load_out = 1'b1;
        sv_d     = rd_node.leaf;
        sym_d    = rd_node.leaf ? rd_node.symbol : '0;
        done_d   = eos_q;
        err_d    = eos_q && !rd_node.leaf && (nxt_q != root_i);
        if (rd_node.leaf || eos_q) begin
          here_vld_d = 1'b0;
        end else begin
          here_vld_d = 1'b1;
          here_d     = rd_node;
          here_idx_d = nxt_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_vld_d = load_out || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      here_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      here_vld_q <= here_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q      <= bit_d;
    eos_q      <= eos_d;
    nxt_q      <= nxt_d;
    here_q     <= here_d;
    here_idx_q <= here_idx_d;
    sv_q       <= sv_d;
    sym_q      <= sym_d;
    done_q     <= done_d;
    err_q      <= err_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(head_i.idx)] <= head_i.node;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      rd_q    <= mem[AW'(rd_idx)];
      rd_ok_q <= 32'(rd_idx) < NODE_COUNT;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign symbol_valid_o   = sv_q;
  assign decoded_symbol_o = sym_q;
  assign stream_done_o    = done_q;
  assign stream_error_o   = err_q;

  // result register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_THERE) |-> slot_free)
    else $error("result register overwritten");

  // an end-of-stream bit always restarts the next walk at the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_THERE && eos_q) |=> !here_vld_q)
    else $error("walk not restarted after end of stream");

  // an error only comes with end of stream and never with a symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(err_q && (sv_q || !done_q)))
    else $error("inconsistent result flags");

  // node memory is written only between walks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_IDLE && !rd_req))
    else $error("node write during walk");

endmodule

// ===== rtl/core/huffman_tree_bit_decoder.sv =====
// top level of the huffman tree bit decoder
//
// usage
//   input channel (in_valid_i / in_stall_o): opcode 0 writes one tree node,
//   opcode 1 decodes one code bit. a write produces no result, every code
//   bit produces one result transaction on the output channel
//   (out_valid_o / out_stall_i).
//   configuration channel (cfg_valid_i / cfg_ready_o) sets the root node;
//   it is always ready. the user must see that it is written only while
//   the block is idle; the block itself does not enforce this.
//   a code bit is resolved by reading the child node of the node held in
//   the back end and then resolving it; a walk that starts at the root
//   reads the root node first. a new command leaves the queue only once the
//   walk of the previous code bit is through, and a code bit only while the
//   result register is free. the single read port of the node memory is why
//   the root and the child node are read one after the other.
//   a two-entry queue parts the input side from the walk, so input keeps
//   flowing while a result waits on a stalled receiver; once the queue is
//   full in_stall_o rises.
//   reset clears the queue, the result valid flag and the walk (next bit
//   starts at the root); node memory contents stay undefined until written.
module huffman_tree_bit_decoder import htbd_pkg::*; #(
  parameter int NODE_COUNT   = NODE_COUNT_DEFAULT,
  parameter int SYMBOL_COUNT = SYM_COUNT_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [IDX_W-1:0] node_index_i,
  input  logic [IDX_W-1:0] left_child_i,
  input  logic [IDX_W-1:0] right_child_i,
  input  logic [SYM_W-1:0] node_symbol_i,
  input  logic             node_is_leaf_i,
  input  logic             code_bit_i,
  input  logic             end_of_stream_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             symbol_valid_o,
  output logic [SYM_W-1:0] decoded_symbol_o,
  output logic             stream_done_o,
  output logic             stream_error_o
);

  logic [IDX_W-1:0] root_q;
  cmd_t             front_cmd;
  cmd_t             head;
  logic             head_valid;
  logic             pop;
  logic             q_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_q <= cfg_data_i;
    end
  end

  htbd_front #(
    .NODE_COUNT   (NODE_COUNT),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .opcode_i        (opcode_i),
    .node_index_i    (node_index_i),
    .left_child_i    (left_child_i),
    .right_child_i   (right_child_i),
    .node_symbol_i   (node_symbol_i),
    .node_is_leaf_i  (node_is_leaf_i),
    .code_bit_i      (code_bit_i),
    .end_of_stream_i (end_of_stream_i),
    .cmd_o           (front_cmd)
  );

  htbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  htbd_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .root_i           (root_q),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .symbol_valid_o   (symbol_valid_o),
    .decoded_symbol_o (decoded_symbol_o),
    .stream_done_o    (stream_done_o),
    .stream_error_o   (stream_error_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the huffman tree bit decoder: code trees and bit streams checked against a tree walk
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import htbd_pkg::*;

  localparam int NODES        = NODE_COUNT_DEFAULT;
  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 8;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
    logic             leaf;
    logic             code_bit;
    logic             eos;
  } stim_t;

  typedef struct packed {
    logic             sym_valid;
    logic [SYM_W-1:0] symbol;
    logic             done;
    logic             err;
  } sym_res_t;

  typedef struct packed {
    stim_t    stim;
    logic     typed;
    sym_res_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             opcode_i;
  logic [IDX_W-1:0] node_index_i;
  logic [IDX_W-1:0] left_child_i;
  logic [IDX_W-1:0] right_child_i;
  logic [SYM_W-1:0] node_symbol_i;
  logic             node_is_leaf_i;
  logic             code_bit_i;
  logic             end_of_stream_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             symbol_valid_o;
  logic [SYM_W-1:0] decoded_symbol_o;
  logic             stream_done_o;
  logic             stream_error_o;

  node_t            tree_mem     [NODES];
  bit               node_written [NODES];
  logic [IDX_W-1:0] walk_node;
  logic [IDX_W-1:0] root_sel;
  bit               walk_fresh;
  sym_res_t         sym_expect_q [$];
  stim_t            tree_q       [$];
  int unsigned      fail_cnt;
  int unsigned      items_sent;
  int unsigned      burst_left;
  bit               hold_req;

  huffman_tree_bit_decoder dut (.*);

  always #5ns clk_i = ~clk_i;

  function automatic bit tree_step(input stim_t s, output sym_res_t r);
    logic [IDX_W-1:0] base_idx;
    logic [IDX_W-1:0] next_idx;
    node_t            here_n;
    node_t            there_n;
    r = '0;
    if (s.op == OP_WRITE) begin
      tree_mem[s.idx]     = '{left: s.left, right: s.right, symbol: s.sym, leaf: s.leaf};
      node_written[s.idx] = 1'b1;
      return 1'b0;
    end
    base_idx = walk_fresh ? root_sel : walk_node;
    here_n   = tree_mem[base_idx];
    next_idx = s.code_bit ? here_n.right : here_n.left;
    there_n  = tree_mem[next_idx];
    if (there_n.leaf) begin
      r.sym_valid = 1'b1;
      r.symbol    = there_n.symbol;
      walk_fresh  = 1'b1;
      walk_node   = root_sel;
    end else begin
      walk_fresh = 1'b0;
      walk_node  = next_idx;
    end
    if (s.eos) begin
      r.done     = 1'b1;
      r.err      = !walk_fresh && walk_node != root_sel;
      walk_fresh = 1'b1;
      walk_node  = root_sel;
    end
    return 1'b1;
  endfunction

  function automatic stim_t rand_stim();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(stim_t)-1:0];
  endfunction

  // next code bit that only steps onto written nodes, or a write that gives the walk a target
  function automatic stim_t plan_decode(input bit loose);
    stim_t            s;
    node_t            here_n;
    logic [IDX_W-1:0] go;
    s      = rand_stim();
    here_n = tree_mem[walk_fresh ? root_sel : walk_node];
    if (!node_written[here_n.left] && !node_written[here_n.right]) begin
      s.op  = OP_WRITE;
      s.idx = here_n.left;
      return s;
    end
    s.op = OP_DECODE;
    go   = s.code_bit ? here_n.right : here_n.left;
    if (!node_written[go]) begin
      s.code_bit = ~s.code_bit;
      go         = s.code_bit ? here_n.right : here_n.left;
    end
    if (loose)
      s.eos = ($urandom_range(1) == 0);
    else if (tree_mem[go].leaf)
      s.eos = ($urandom_range(5) == 0);
    else
      s.eos = ($urandom_range(29) == 0);
    return s;
  endfunction

  // merges random subtrees pairwise, parents written after children; returns the top index
  function automatic logic [IDX_W-1:0] plan_tree(input int unsigned leaves, input int forced);
    logic [IDX_W-1:0] pool [$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    stim_t            s;
    int unsigned      k;
    repeat (leaves) begin
      s      = rand_stim();
      s.op   = OP_WRITE;
      s.leaf = 1'b1;
      tree_q.push_back(s);
      pool.push_back(s.idx);
    end
    while (pool.size() > 1) begin
      k = $urandom_range(pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      s       = rand_stim();
      s.op    = OP_WRITE;
      s.leaf  = 1'b0;
      s.left  = a;
      s.right = b;
      if (pool.size() == 0 && forced >= 0) s.idx = IDX_W'(forced);
      tree_q.push_back(s);
      pool.push_back(s.idx);
    end
    return pool[0];
  endfunction

  function automatic dir_row_t wr_row(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] l,
                                      input logic [IDX_W-1:0] r, input logic [SYM_W-1:0] sym,
                                      input logic leaf);
    dir_row_t d;
    d             = '0;
    d.stim.op     = OP_WRITE;
    d.stim.idx    = idx;
    d.stim.left   = l;
    d.stim.right  = r;
    d.stim.sym    = sym;
    d.stim.leaf   = leaf;
    return d;
  endfunction

  function automatic dir_row_t dec_row(input logic code_bit, input logic eos, input logic sv,
                                       input logic [SYM_W-1:0] sym, input logic done,
                                       input logic err);
    dir_row_t d;
    d               = '0;
    d.stim.op       = OP_DECODE;
    d.stim.code_bit = code_bit;
    d.stim.eos      = eos;
    d.typed         = 1'b1;
    d.want          = '{sym_valid: sv, symbol: sym, done: done, err: err};
    return d;
  endfunction

  task automatic send_item(input stim_t s, input bit typed, input sym_res_t want);
    sym_res_t    pred;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    opcode_i        <= s.op;
    node_index_i    <= s.idx;
    left_child_i    <= s.left;
    right_child_i   <= s.right;
    node_symbol_i   <= s.sym;
    node_is_leaf_i  <= s.leaf;
    code_bit_i      <= s.code_bit;
    end_of_stream_i <= s.eos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (tree_step(s, pred)) sym_expect_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sym_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_root(input logic [IDX_W-1:0] r);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    root_sel = r;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    sym_res_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (sym_expect_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: unexpected transaction: valid %0b symbol %02h done %0b error %0b",
                   $time, symbol_valid_o, decoded_symbol_o, stream_done_o, stream_error_o);
        fail_cnt++;
      end else begin
        want = sym_expect_q.pop_front();
        if (symbol_valid_o !== want.sym_valid || decoded_symbol_o !== want.symbol ||
            stream_done_o !== want.done || stream_error_o !== want.err) begin
          if (fail_cnt < 10)
            $display("%0t: expected valid %0b symbol %02h done %0b error %0b, got %0b %02h %0b %0b",
                     $time, want.sym_valid, want.symbol, want.done, want.err,
                     symbol_valid_o, decoded_symbol_o, stream_done_o, stream_error_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(40, 5);
      repeat (span) begin
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(3) == 0);
          2:       out_stall_i <= ($urandom_range(3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    dir_row_t         dir_tab [DIR_ROWS];
    stim_t            s;
    logic [IDX_W-1:0] top;
    int unsigned      phase;
    int unsigned      next_hold;
    int unsigned      kind;
    int unsigned      leaves;
    int               forced;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    opcode_i        <= 1'b0;
    node_index_i    <= '0;
    left_child_i    <= '0;
    right_child_i   <= '0;
    node_symbol_i   <= '0;
    node_is_leaf_i  <= 1'b0;
    code_bit_i      <= 1'b0;
    end_of_stream_i <= 1'b0;
    for (int i = 0; i < NODES; i++) begin
      tree_mem[i]     = '0;
      node_written[i] = 1'b0;
    end
    walk_fresh = 1'b1;
    walk_node  = '0;
    root_sel   = '0;
    fail_cnt   = 0;
    items_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;

    // root stays at its reset value here
    dir_tab = '{
      wr_row(9'd0,   9'd1,   9'd2,   8'h00, 1'b0),
      wr_row(9'd1,   9'd0,   9'd0,   8'h00, 1'b1),
      wr_row(9'd2,   9'd3,   9'd511, 8'h00, 1'b0),
      wr_row(9'd3,   9'd511, 9'd511, 8'hff, 1'b1),
      wr_row(9'd511, 9'd0,   9'd3,   8'ha5, 1'b0),
      dec_row(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b0, 1'b0, 1'b1, 8'hff, 1'b0, 1'b0),
      // stream ends inside a code
      dec_row(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      // child link back to the root ends the stream cleanly
      dec_row(1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0),
      dec_row(1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0),
      // root marked as leaf is not checked on its own
      wr_row(9'd0,   9'd1,   9'd2,   8'h5a, 1'b1),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b1, 8'hff, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b0, 1'b0, 1'b1, 8'h5a, 1'b0, 1'b0),
      wr_row(9'd0,   9'd1,   9'd2,   8'h00, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
      dec_row(1'b0, 1'b0, 1'b1, 8'hff, 1'b0, 1'b0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    drain();

    phase     = 0;
    next_hold = 2;
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        leaves = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 2);
        case ($urandom_range(5))
          0:       forced = 0;
          1:       forced = NODES - 1;
          default: forced = -1;
        endcase
        top = plan_tree(leaves, forced);
        while (tree_q.size() != 0) send_item(tree_q.pop_front(), 1'b0, '0);
        drain();
        set_root(top);
        if (phase >= next_hold) begin
          hold_req  = 1'b1;
          next_hold = phase + 10;
        end
        repeat ($urandom_range(60, 10)) begin
          if ($urandom_range(14) == 0) begin
            s    = rand_stim();
            s.op = OP_WRITE;
          end else begin
            s = plan_decode(1'b0);
          end
          send_item(s, 1'b0, '0);
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(40, 15)) begin
          if ($urandom_range(2) == 0) begin
            s    = rand_stim();
            s.op = OP_WRITE;
          end else begin
            s = plan_decode(1'b1);
          end
          send_item(s, 1'b0, '0);
        end
      end else begin
        // new root while the walk may still be inside a code
        do top = IDX_W'($urandom_range(NODES - 1)); while (!node_written[top]);
        set_root(top);
        repeat ($urandom_range(40, 20)) send_item(plan_decode(1'b0), 1'b0, '0);
      end
      drain();
      phase++;
    end

    drain();
    if (fail_cnt == 0 && sym_expect_q.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== huffman_tree_bit_decoder.f =====
rtl/core/htbd_pkg.sv
rtl/core/htbd_front.sv
rtl/core/htbd_queue.sv
rtl/core/htbd_back.sv
rtl/core/huffman_tree_bit_decoder.sv
sim/tb_top.sv
